@@ rtl/wm_pkg.sv @@
// ----------------------------------------------------------------------------
// Window median package
// Shared widths, request types and control groups of the window median block.
// ----------------------------------------------------------------------------
package wm_pkg;

    localparam int unsigned SAMPLE_W        = 32;
    localparam int unsigned COUNT_W         = 7;
    localparam int unsigned MAX_SAMPLES_DEF = 64;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic [COUNT_W-1:0]  sample_count;
        logic                overflow;
    } out_item_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic               load;
        logic               odd;
        logic               overflow;
        logic [COUNT_W-1:0] count;
    } mid_ctl_t;

endpackage

@@ rtl/wm_cell.sv @@
// ----------------------------------------------------------------------------
// Window median sorting cell
// One slot of the ordered row: takes the new sample or its left neighbor's
// value on insertion, and its right neighbor's value while the row drains.
// ----------------------------------------------------------------------------
module wm_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 7
) (
    input  logic                        aclk,
    input  wm_pkg::cell_ctl_t           ctl,
    input  logic [CW-1:0]               fill,
    input  logic [wm_pkg::SAMPLE_W-1:0] sample,
    input  logic [wm_pkg::SAMPLE_W-1:0] left_val,
    input  logic                        left_gt,
    input  logic [wm_pkg::SAMPLE_W-1:0] right_val,
    output logic [wm_pkg::SAMPLE_W-1:0] val,
    output logic                        gt
);

    localparam logic [CW-1:0] IDX_V = CW'(IDX);

    logic [wm_pkg::SAMPLE_W-1:0] val_reg;
    logic [wm_pkg::SAMPLE_W-1:0] val_next;
    logic                        occupied;
    logic                        at_fill;

    assign occupied = (IDX_V < fill);
    assign at_fill  = (IDX_V == fill);
    assign gt       = occupied && (val_reg > sample);
    assign val      = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ctl.insert && (gt || at_fill)) begin
            val_next = left_gt ? left_val : sample;
        end else if (ctl.shift) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

@@ rtl/wm_mid.sv @@
// ----------------------------------------------------------------------------
// Window median result stage
// Forms the median from the two lowest cells and holds the result request
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module wm_mid (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wm_pkg::mid_ctl_t            ctl,
    input  logic [wm_pkg::SAMPLE_W-1:0] lo,
    input  logic [wm_pkg::SAMPLE_W-1:0] hi,
    output logic                        m_valid,
    input  logic                        m_ready,
    output wm_pkg::out_item_t           m_item
);

    logic [wm_pkg::SAMPLE_W:0]   sum;
    logic [wm_pkg::SAMPLE_W-1:0] median;
    logic                        valid_reg;
    logic                        valid_next;
    wm_pkg::out_item_t           item_reg;
    wm_pkg::out_item_t           item_next;

    assign sum    = {1'b0, lo} + {1'b0, hi};
    assign median = ctl.odd ? lo : sum[wm_pkg::SAMPLE_W:1];

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (ctl.load) begin
            valid_next             = 1'b1;
            item_next.median       = median;
            item_next.sample_count = ctl.count;
            item_next.overflow     = ctl.overflow;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

@@ rtl/window_median_top.sv @@
// ----------------------------------------------------------------------------
// Window median top level
// Sorts each window of samples into a row of cells and reports its median.
//
//   Channel   Ports                          Carries
//   input     s_valid, s_ready, s_item       one sample and its last flag
//   result    m_valid, m_ready, m_item       median, sample count, overflow
//
// A sample is taken in every cycle while a window fills; the cell row inserts
// it in order in that same cycle. A window of n samples keeps k of them, with
// k being n capped at MAX_SAMPLES. After its last sample the row shifts down
// floor((k-1)/2) places and then the result is formed. s_ready is low while
// the row drains, and the final step waits while an earlier result is still
// held. Reset empties the row and clears the result request.
// ----------------------------------------------------------------------------
module window_median_top #(
    parameter int unsigned MAX_SAMPLES = wm_pkg::MAX_SAMPLES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wm_pkg::in_item_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output wm_pkg::out_item_t m_item
);

    localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned IDX1 = (MAX_SAMPLES > 1) ? 1 : 0;
    localparam logic [CW-1:0] MAX_V = CW'(MAX_SAMPLES);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [CW-1:0]               fill_reg;
    logic [CW-1:0]               fill_next;
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic                        drop_reg;
    logic                        drop_next;
    logic                        accept;
    logic                        full;
    logic [CW-1:0]               n_new;
    logic                        load;
    wm_pkg::cell_ctl_t           cell_ctl;
    wm_pkg::mid_ctl_t            mid_ctl;
    logic [wm_pkg::SAMPLE_W-1:0] cell_val [MAX_SAMPLES];
    logic                        cell_gt  [MAX_SAMPLES];

    assign s_ready = (state_reg == ST_FILL);
    assign accept  = s_valid && s_ready;
    assign full    = (fill_reg == MAX_V);
    assign n_new   = full ? fill_reg : fill_reg + CW'(1);
    assign load    = (state_reg == ST_DRAIN) && (cnt_reg == '0) && (!m_valid || m_ready);

    assign cell_ctl.insert = accept && !full;
    assign cell_ctl.shift  = (state_reg == ST_DRAIN) && (cnt_reg != '0);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (accept) begin
                    fill_next = n_new;
                    drop_next = drop_reg || full;
                    if (s_item.last) begin
                        cnt_next   = (n_new - CW'(1)) >> 1;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - CW'(1);
                end else if (load) begin
                    fill_next  = '0;
                    drop_next  = 1'b0;
                    state_next = ST_FILL;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
        end
    end

    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        wm_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl),
            .fill      (fill_reg),
            .sample    (s_item.sample),
            .left_val  ((i == 0) ? '0 : cell_val[(i == 0) ? 0 : i - 1]),
            .left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
            .right_val (cell_val[(i == MAX_SAMPLES - 1) ? i : i + 1]),
            .val       (cell_val[i]),
            .gt        (cell_gt[i])
        );
    end

    assign mid_ctl.load     = load;
    assign mid_ctl.odd      = fill_reg[0];
    assign mid_ctl.overflow = drop_reg;
    assign mid_ctl.count    = wm_pkg::COUNT_W'(fill_reg);

    wm_mid u_mid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mid_ctl),
        .lo      (cell_val[0]),
        .hi      (cell_val[IDX1]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    a_last_stops_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.last) |=> !s_ready)
        else $error("input still open after the last sample of a window");

    a_result_from_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DRAIN))
        else $error("result request raised outside the drain step");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= MAX_V)
        else $error("fill count beyond the row length");

    a_drain_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (fill_reg != '0))
        else $error("draining an empty window");

endmodule
